### src/speck_pkg.sv
package speck_pkg;

    localparam int ROUNDS_DEF = 32;
    localparam int WORD_W     = 64;
    localparam int REQ_W      = 3;

    // request codes carried in the input tuser field
    localparam logic [REQ_W-1:0] REQ_LOAD_IV = 3'd0;
    localparam logic [REQ_W-1:0] REQ_ECB_ENC = 3'd1;
    localparam logic [REQ_W-1:0] REQ_ECB_DEC = 3'd2;
    localparam logic [REQ_W-1:0] REQ_CBC_ENC = 3'd3;
    localparam logic [REQ_W-1:0] REQ_CBC_DEC = 3'd4;

    // configuration register indexes
    localparam logic CFG_KEY_HIGH = 1'b0;
    localparam logic CFG_KEY_LOW  = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXPAND,
        ST_PREFETCH,
        ST_ROUND,
        ST_FINISH
    } state_t;

    typedef struct packed {
        logic start;     // latch a block transaction
        logic load_iv;   // load the chain register from the input
        logic expand;    // one key schedule step
        logic prefetch;  // issue the first round key read
        logic round;     // one cipher round
        logic finish;    // load the output register, update the chain in CBC modes
    } cmd_t;

    typedef struct packed {
        logic keys_ready;
        logic cnt_last;
        logic out_free;
    } status_t;

    function automatic logic [WORD_W-1:0] rotr8(input logic [WORD_W-1:0] v);
        rotr8 = {v[7:0], v[WORD_W-1:8]};
    endfunction

    function automatic logic [WORD_W-1:0] rotl3(input logic [WORD_W-1:0] v);
        rotl3 = {v[WORD_W-4:0], v[WORD_W-1:WORD_W-3]};
    endfunction

    function automatic logic [WORD_W-1:0] rotr3(input logic [WORD_W-1:0] v);
        rotr3 = {v[2:0], v[WORD_W-1:3]};
    endfunction

    function automatic logic [WORD_W-1:0] rotl8(input logic [WORD_W-1:0] v);
        rotl8 = {v[WORD_W-9:0], v[WORD_W-1:WORD_W-8]};
    endfunction

endpackage

### src/speck_ctrl.sv
module speck_ctrl
    import speck_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             s_tvalid,
    input  logic [REQ_W-1:0] req,
    output logic             s_tready,
    input  status_t          status,
    output cmd_t             cmd
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid && (req inside {REQ_ECB_ENC, REQ_ECB_DEC, REQ_CBC_ENC, REQ_CBC_DEC}))
                begin
                    state_next = status.keys_ready ? ST_PREFETCH : ST_EXPAND;
                end
            end
            ST_EXPAND:
            begin
                if (status.cnt_last)
                begin
                    state_next = ST_PREFETCH;
                end
            end
            ST_PREFETCH:
            begin
                state_next = ST_ROUND;
            end
            ST_ROUND:
            begin
                if (status.cnt_last)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (status.out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd      = '0;
        s_tready = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    case (req)
                        REQ_LOAD_IV:
                        begin
                            cmd.load_iv = 1'b1;
                        end
                        REQ_ECB_ENC, REQ_ECB_DEC, REQ_CBC_ENC, REQ_CBC_DEC:
                        begin
                            cmd.start = 1'b1;
                        end
                        default:
                        begin
                            // unused code: drop the transaction
                        end
                    endcase
                end
            end
            ST_EXPAND:
            begin
                cmd.expand = 1'b1;
            end
            ST_PREFETCH:
            begin
                cmd.prefetch = 1'b1;
            end
            ST_ROUND:
            begin
                cmd.round = 1'b1;
            end
            ST_FINISH:
            begin
                cmd.finish = status.out_free;
            end
            default:
            begin
            end
        endcase
    end

endmodule

### src/speck_datapath.sv
module speck_datapath
    import speck_pkg::*;
#(
    parameter int ROUNDS = ROUNDS_DEF
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_we,
    input  logic                cfg_index,
    input  logic [WORD_W-1:0]   cfg_data,
    input  logic [REQ_W-1:0]    req,
    input  logic [WORD_W-1:0]   data_high,
    input  logic [WORD_W-1:0]   data_low,
    input  cmd_t                cmd,
    output status_t             status,
    input  logic                m_tready,
    output logic                m_tvalid,
    output logic [WORD_W-1:0]   result_high,
    output logic [WORD_W-1:0]   result_low
);

    localparam int CNT_W = $clog2(ROUNDS);

    logic [WORD_W-1:0] key_high_reg;
    logic [WORD_W-1:0] key_low_reg;
    logic              keys_ready_reg;
    logic [WORD_W-1:0] chain_high_reg;
    logic [WORD_W-1:0] chain_low_reg;
    logic [WORD_W-1:0] in_high_reg;
    logic [WORD_W-1:0] in_low_reg;
    logic [REQ_W-1:0]  req_reg;
    logic [WORD_W-1:0] a_reg;
    logic [WORD_W-1:0] b_reg;
    logic [WORD_W-1:0] a_next;
    logic [WORD_W-1:0] b_next;
    logic [WORD_W-1:0] l_reg;
    logic [WORD_W-1:0] k_reg;
    logic [WORD_W-1:0] l_next;
    logic [WORD_W-1:0] k_next;
    logic [CNT_W-1:0]  cnt_reg;
    logic [CNT_W-1:0]  idx;
    logic [CNT_W-1:0]  rd_addr;
    logic [WORD_W-1:0] rk_reg;
    logic [WORD_W-1:0] round_keys [ROUNDS];
    logic              out_valid_reg;
    logic [WORD_W-1:0] res_high_reg;
    logic [WORD_W-1:0] res_low_reg;
    logic              dec;
    logic              cbc_enc_start;
    logic [WORD_W-1:0] dec_b;

    assign dec           = (req_reg == REQ_ECB_DEC) || (req_reg == REQ_CBC_DEC);
    assign cbc_enc_start = (req == REQ_CBC_ENC);

    // key schedule step
    assign l_next = (rotr8(l_reg) + k_reg) ^ WORD_W'(cnt_reg);
    assign k_next = rotl3(k_reg) ^ l_next;

    // one round forward or backward
    assign dec_b = rotr3(b_reg ^ a_reg);
    always_comb
    begin
        if (dec)
        begin
            b_next = dec_b;
            a_next = rotl8((a_reg ^ rk_reg) - dec_b);
        end
        else
        begin
            a_next = (rotr8(a_reg) + b_reg) ^ rk_reg;
            b_next = rotl3(b_reg) ^ a_next;
        end
    end

    // round key read address: forward for encrypt, reversed for decrypt
    assign idx     = cmd.prefetch ? '0 : cnt_reg + CNT_W'(1);
    assign rd_addr = dec ? CNT_W'(ROUNDS - 1) - idx : idx;

    always_ff @(posedge clk)
    begin
        if (cmd.expand)
        begin
            round_keys[cnt_reg] <= k_reg;
        end
        if (cmd.prefetch || cmd.round)
        begin
            rk_reg <= round_keys[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_high_reg   <= '0;
            key_low_reg    <= '0;
            keys_ready_reg <= 1'b0;
            chain_high_reg <= '0;
            chain_low_reg  <= '0;
            cnt_reg        <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                if (cfg_index == CFG_KEY_HIGH)
                begin
                    key_high_reg <= cfg_data;
                end
                else
                begin
                    key_low_reg <= cfg_data;
                end
                keys_ready_reg <= 1'b0;
            end
            else if (cmd.expand && status.cnt_last)
            begin
                keys_ready_reg <= 1'b1;
            end

            if (cmd.start || cmd.prefetch)
            begin
                cnt_reg <= '0;
            end
            else if (cmd.expand || cmd.round)
            begin
                cnt_reg <= cnt_reg + CNT_W'(1);
            end

            if (cmd.load_iv)
            begin
                chain_high_reg <= data_high;
                chain_low_reg  <= data_low;
            end
            else if (cmd.finish && req_reg == REQ_CBC_ENC)
            begin
                chain_high_reg <= a_reg;
                chain_low_reg  <= b_reg;
            end
            else if (cmd.finish && req_reg == REQ_CBC_DEC)
            begin
                chain_high_reg <= in_high_reg;
                chain_low_reg  <= in_low_reg;
            end

            if (cmd.finish)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            req_reg     <= req;
            in_high_reg <= data_high;
            in_low_reg  <= data_low;
            a_reg       <= cbc_enc_start ? data_high ^ chain_high_reg : data_high;
            b_reg       <= cbc_enc_start ? data_low ^ chain_low_reg : data_low;
            l_reg       <= key_high_reg;
            k_reg       <= key_low_reg;
        end
        else
        begin
            if (cmd.expand)
            begin
                l_reg <= l_next;
                k_reg <= k_next;
            end
            if (cmd.round)
            begin
                a_reg <= a_next;
                b_reg <= b_next;
            end
        end
        if (cmd.finish)
        begin
            if (req_reg == REQ_CBC_DEC)
            begin
                res_high_reg <= a_reg ^ chain_high_reg;
                res_low_reg  <= b_reg ^ chain_low_reg;
            end
            else
            begin
                res_high_reg <= a_reg;
                res_low_reg  <= b_reg;
            end
        end
    end

    assign status.keys_ready = keys_ready_reg;
    assign status.cnt_last   = (cnt_reg == CNT_W'(ROUNDS - 1));
    assign status.out_free   = !out_valid_reg || m_tready;

    assign m_tvalid    = out_valid_reg;
    assign result_high = res_high_reg;
    assign result_low  = res_low_reg;

endmodule

### src/speck128_cbc_cipher_unit.sv
// Speck128/128 cipher unit with ECB and CBC modes. Each input transaction
// carries a request type in s_tuser and one 128-bit block in s_tdata: load
// IV (no result), ECB encrypt, ECB decrypt, CBC encrypt or CBC decrypt;
// unused request codes are dropped without a result. Every cipher request
// yields exactly one output transaction. The key is written through the
// cfg port (index 0 = upper key word, index 1 = lower key word); a key
// write marks the round-key store stale, and the next cipher request first
// runs the key schedule, one round key per cycle, into a ROUNDS-entry store
// (32 entries by default). After acceptance, a block goes through the first
// round-key read, the rounds (one round per cycle through a single shared
// round unit) and, once the output register is free, the final chaining
// step into it; the key schedule runs before these when it has to. One
// block is in flight at a time. A finished result waits in the output
// register, and a load IV request is taken while it waits. Write the key
// only while idle.
module speck128_cbc_cipher_unit
    import speck_pkg::*;
#(
    parameter int ROUNDS = ROUNDS_DEF
)
(
    input  logic               clk,
    input  logic               rst_n,
    // configuration write port
    input  logic               cfg_we,
    input  logic               cfg_index,
    input  logic [WORD_W-1:0]  cfg_data,
    // input stream
    input  logic               s_tvalid,
    output logic               s_tready,
    input  logic [127:0]       s_tdata,   // data_high [63:0], data_low [127:64]
    input  logic [7:0]         s_tuser,   // req_type [2:0], zero above
    // output stream
    output logic               m_tvalid,
    input  logic               m_tready,
    output logic [127:0]       m_tdata    // result_high [63:0], result_low [127:64]
);

    cmd_t              cmd;
    status_t           status;
    logic [REQ_W-1:0]  req;
    logic [WORD_W-1:0] result_high;
    logic [WORD_W-1:0] result_low;

    assign req = s_tuser[REQ_W-1:0];

    // sequence each transaction: key schedule, rounds, output hand-off
    speck_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .req      (req),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    // hold key, chain, round-key store, round state and output register
    speck_datapath #(
        .ROUNDS (ROUNDS)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .req         (req),
        .data_high   (s_tdata[63:0]),
        .data_low    (s_tdata[127:64]),
        .cmd         (cmd),
        .status      (status),
        .m_tready    (m_tready),
        .m_tvalid    (m_tvalid),
        .result_high (result_high),
        .result_low  (result_low)
    );

    assign m_tdata = {result_low, result_high};

endmodule
